// ===== rtl/chm_pkg.sv =====
// Package for the chained hash map engine: sizes, codes, the controller
// state type and the control and status structs shared by the modules.
// No dependencies.
package chm_pkg;

    localparam int MAX_BUCKET_BITS_DEF = 7;
    localparam int NODE_COUNT_DEF      = 256;
    localparam int KEY_WIDTH_DEF       = 64;
    localparam int VALUE_WIDTH_DEF     = 64;

    localparam int MIN_BUCKET_BITS = 4;
    localparam int CMD_W           = 2;
    localparam int KEY_W           = 64;
    localparam int VAL_W           = 64;
    localparam int STATUS_W        = 3;
    localparam int COUNT_W         = 9;
    localparam int BB_W            = 3;
    localparam int GROUP_W         = 16;

    localparam logic [BB_W-1:0] BUCKET_BITS_RESET = 3'd7;

    localparam logic [CMD_W-1:0] CMD_PUT    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_GET    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_ADDED     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_UPDATED   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_POOL_FULL = 3'd5;

    localparam logic [0:0] REG_BUCKET_BITS = 1'b0;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HEAD,
        S_START,
        S_CHECK,
        S_CMP,
        S_ACT,
        S_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic start;
        logic step;
        logic hit;
        logic act;
    } t_ctl;

    typedef struct packed {
        logic in_valid;
        logic out_ready;
        logic node_ok;
        logic key_match;
    } t_sts;

endpackage

// ===== rtl/chm_if.sv =====
// Channel interfaces of the chained hash map engine.
// Depends on chm_pkg.
interface chm_req_if import chm_pkg::*;;
    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] cmd;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;

    modport source (output valid, cmd, key, value, input ready);
    modport sink   (input valid, cmd, key, value, output ready);
endinterface

interface chm_rsp_if import chm_pkg::*;;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [VAL_W-1:0]    found_value;
    logic [COUNT_W-1:0]  entry_count;

    modport source (output valid, status, found_value, entry_count, input ready);
    modport sink   (input valid, status, found_value, entry_count, output ready);
endinterface

// ===== rtl/chm_ctrl.sv =====
// Controller of the chained hash map engine: sequences head read, chain
// walk, update and result hand-off. Depends on chm_pkg.
module chm_ctrl import chm_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_sts i_sts,
    output t_ctl o_ctl,
    output logic o_in_ready,
    output logic o_out_valid
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_ctl       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_sts.in_valid) begin
                    o_ctl.load = 1'b1;
                    n_state    = S_HEAD;
                end
            end
            S_HEAD: begin
                n_state = S_START;
            end
            S_START: begin
                o_ctl.start = 1'b1;
                n_state     = S_CHECK;
            end
            S_CHECK: begin
                n_state = i_sts.node_ok ? S_CMP : S_ACT;
            end
            S_CMP: begin
                if (i_sts.key_match) begin
                    o_ctl.hit = 1'b1;
                    n_state   = S_ACT;
                end else begin
                    o_ctl.step = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_ACT: begin
                o_ctl.act = 1'b1;
                n_state   = S_OUT;
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (i_sts.out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/chm_datapath.sv =====
// Datapath of the chained hash map engine: hash, bucket heads, node memories,
// free-node finder and result registers. Depends on chm_pkg.
module chm_datapath import chm_pkg::*; #(
    parameter int MAX_BUCKET_BITS = MAX_BUCKET_BITS_DEF,
    parameter int NODE_COUNT      = NODE_COUNT_DEF,
    parameter int KEY_WIDTH       = KEY_WIDTH_DEF,
    parameter int VALUE_WIDTH     = VALUE_WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_ctl                i_ctl,
    output logic                o_node_ok,
    output logic                o_key_match,
    input  logic [CMD_W-1:0]    i_cmd,
    input  logic [KEY_W-1:0]    i_key,
    input  logic [VAL_W-1:0]    i_value,
    input  logic [BB_W-1:0]     i_bucket_bits,
    output logic [STATUS_W-1:0] o_status,
    output logic [VAL_W-1:0]    o_found_value,
    output logic [COUNT_W-1:0]  o_entry_count
);

    localparam int SLOTS  = 1 << MAX_BUCKET_BITS;
    localparam int BKT_W  = MAX_BUCKET_BITS;
    localparam int IDX_W  = $clog2(NODE_COUNT);
    localparam int PTR_W  = $clog2(NODE_COUNT + 1);
    localparam int NG     = NODE_COUNT / GROUP_W;
    localparam int GI_W   = (NG > 1) ? $clog2(NG) : 1;
    localparam int CB_W   = $clog2(MAX_BUCKET_BITS + 1);
    localparam logic [PTR_W-1:0] NIL = PTR_W'(NODE_COUNT);

    logic [PTR_W-1:0]       mem_head [SLOTS];
    logic [KEY_WIDTH-1:0]   mem_key  [NODE_COUNT];
    logic [VALUE_WIDTH-1:0] mem_val  [NODE_COUNT];
    logic [PTR_W-1:0]       mem_link [NODE_COUNT];

    logic [SLOTS-1:0]       r_head_vld;
    logic [NODE_COUNT-1:0]  r_in_use;
    logic [PTR_W-1:0]       r_count;

    logic [CMD_W-1:0]       r_cmd;
    logic [KEY_WIDTH-1:0]   r_key;
    logic [VALUE_WIDTH-1:0] r_val;
    logic [BKT_W-1:0]       r_bucket;
    logic [PTR_W-1:0]       r_head_q;
    logic                   r_head_vq;
    logic [PTR_W-1:0]       r_first;
    logic [PTR_W-1:0]       r_cur;
    logic [PTR_W-1:0]       r_prev;
    logic                   r_hit;
    logic [KEY_WIDTH-1:0]   r_key_q;
    logic [VALUE_WIDTH-1:0] r_val_q;
    logic [PTR_W-1:0]       r_link_q;

    logic [NG-1:0]          r_grp_free;
    logic [GI_W-1:0]        r_grp_idx;
    logic                   r_grp_any;
    logic [IDX_W-1:0]       r_free_node;
    logic                   r_free_ok;

    logic [STATUS_W-1:0]    r_status;
    logic [VALUE_WIDTH-1:0] r_found;

    logic [IDX_W-1:0]       cur_idx;
    logic [IDX_W-1:0]       prev_idx;
    logic [KEY_WIDTH-1:0]   key_in;
    logic [KEY_W-1:0]       h1;
    logic [KEY_W-1:0]       h2;
    logic [CB_W-1:0]        cb;
    logic [BKT_W-1:0]       mask;
    logic                   is_put;
    logic                   is_get;
    logic                   is_rm;
    logic                   put_new;
    logic                   rm_hit;
    logic [GI_W-1:0]        n_grp_idx;
    logic                   n_grp_any;
    logic [IDX_W-1:0]       n_free_node;
    logic [GROUP_W-1:0]     grp_word;

    assign cur_idx  = r_cur[IDX_W-1:0];
    assign prev_idx = r_prev[IDX_W-1:0];
    assign key_in   = i_key[KEY_WIDTH-1:0];

    // Fold the key into the bucket index with the clamped bucket count.
    always_comb begin
        h1 = KEY_W'(key_in) ^ (KEY_W'(key_in) >> 32);
        h2 = h1 ^ (h1 >> 16);
        if (int'(i_bucket_bits) < MIN_BUCKET_BITS) begin
            cb = CB_W'(MIN_BUCKET_BITS);
        end else if (int'(i_bucket_bits) > MAX_BUCKET_BITS) begin
            cb = CB_W'(MAX_BUCKET_BITS);
        end else begin
            cb = CB_W'(i_bucket_bits);
        end
        mask = ~({BKT_W{1'b1}} << cb);
    end

    assign is_put  = (r_cmd == CMD_PUT);
    assign is_get  = (r_cmd == CMD_GET);
    assign is_rm   = (r_cmd == CMD_REMOVE);
    assign put_new = i_ctl.act && is_put && !r_hit && r_free_ok;
    assign rm_hit  = i_ctl.act && is_rm && r_hit;

    assign o_node_ok   = (r_cur < NIL) && r_in_use[cur_idx];
    assign o_key_match = (r_key_q == r_key);

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd    <= i_cmd;
            r_key    <= key_in;
            r_val    <= i_value[VALUE_WIDTH-1:0];
            r_bucket <= h2[BKT_W-1:0] & mask;
        end
        r_head_q <= mem_head[r_bucket];
        if (i_ctl.start) begin
            r_cur   <= r_head_vq ? r_head_q : NIL;
            r_first <= r_head_vq ? r_head_q : NIL;
            r_prev  <= NIL;
        end else if (i_ctl.step) begin
            r_prev <= r_cur;
            r_cur  <= r_link_q;
        end
        r_key_q  <= mem_key[cur_idx];
        r_val_q  <= mem_val[cur_idx];
        r_link_q <= mem_link[cur_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_vld <= '0;
            r_in_use   <= '0;
            r_count    <= '0;
            r_hit      <= 1'b0;
            r_head_vq  <= 1'b0;
        end else begin
            r_head_vq <= r_head_vld[r_bucket];
            if (i_ctl.load) begin
                r_hit <= 1'b0;
            end else if (i_ctl.hit) begin
                r_hit <= 1'b1;
            end
            if (put_new) begin
                r_head_vld[r_bucket]  <= 1'b1;
                r_in_use[r_free_node] <= 1'b1;
                r_count               <= r_count + 1'b1;
            end else if (rm_hit) begin
                r_in_use[cur_idx] <= 1'b0;
                if (r_count != '0) begin
                    r_count <= r_count - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (put_new) begin
            mem_head[r_bucket] <= PTR_W'(r_free_node);
        end else if (rm_hit && r_prev == NIL) begin
            mem_head[r_bucket] <= r_link_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (put_new) begin
            mem_key[r_free_node] <= r_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (put_new) begin
            mem_val[r_free_node] <= r_val;
        end else if (i_ctl.act && is_put && r_hit) begin
            mem_val[cur_idx] <= r_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (put_new) begin
            mem_link[r_free_node] <= r_first;
        end else if (rm_hit && r_prev != NIL) begin
            mem_link[prev_idx] <= r_link_q;
        end
    end

    // The lowest free node is found in three registered steps: free flags per
    // group of sixteen, the first group with a free node, the bit within it.
    always_comb begin
        n_grp_idx = '0;
        n_grp_any = 1'b0;
        for (int g = NG - 1; g >= 0; g--) begin
            if (r_grp_free[g]) begin
                n_grp_idx = GI_W'(g);
                n_grp_any = 1'b1;
            end
        end
        grp_word    = r_in_use[int'(r_grp_idx) * GROUP_W +: GROUP_W];
        n_free_node = '0;
        for (int b = GROUP_W - 1; b >= 0; b--) begin
            if (!grp_word[b]) begin
                n_free_node = IDX_W'(int'(r_grp_idx) * GROUP_W + b);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grp_free <= '0;
            r_grp_any  <= 1'b0;
            r_free_ok  <= 1'b0;
        end else begin
            for (int g = 0; g < NG; g++) begin
                r_grp_free[g] <= ~&r_in_use[g * GROUP_W +: GROUP_W];
            end
            r_grp_any <= n_grp_any;
            r_free_ok <= r_grp_any;
        end
        r_grp_idx   <= n_grp_idx;
        r_free_node <= n_free_node;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.act) begin
            r_found  <= '0;
            r_status <= ST_NOT_FOUND;
            if (is_put) begin
                if (r_hit) begin
                    r_status <= ST_UPDATED;
                end else if (r_free_ok) begin
                    r_status <= ST_ADDED;
                end else begin
                    r_status <= ST_POOL_FULL;
                end
            end else if (is_get && r_hit) begin
                r_status <= ST_FOUND;
                r_found  <= r_val_q;
            end else if (is_rm && r_hit) begin
                r_status <= ST_REMOVED;
            end
        end
    end

    assign o_status      = r_status;
    assign o_found_value = VAL_W'(r_found);
    assign o_entry_count = COUNT_W'(r_count);

endmodule

// ===== rtl/chained_hash_map_engine.sv =====
// Channel    Dir  Handshake       Payload
// i_req      in   valid/ready     cmd, key, value
// o_rsp      out  valid/ready     status, found_value, entry_count
// APB        in   psel/penable    bucket_bits at byte address 0
//
// An item goes from acceptance through a bucket head read, a start step, a check and
// a compare per chain node until the key matches or the chain ends, then the update
// and the result; each node costs one node-memory read and one compare.
// One item is in work at a time; the next is accepted in the cycle after the result
// is taken, so a stalled result holds off the input.
// Reset is synchronous and active low and clears bucket heads and node use
// marks at once; no clearing pass is needed.
// Top level of the chained hash map engine. Depends on chm_pkg, chm_if,
// chm_ctrl and chm_datapath.
module chained_hash_map_engine import chm_pkg::*; #(
    parameter int MAX_BUCKET_BITS = MAX_BUCKET_BITS_DEF,
    parameter int NODE_COUNT      = NODE_COUNT_DEF,
    parameter int KEY_WIDTH       = KEY_WIDTH_DEF,
    parameter int VALUE_WIDTH     = VALUE_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    chm_req_if.sink     i_req,
    chm_rsp_if.source   o_rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [BB_W-1:0] r_bucket_bits;
    t_ctl            ctl;
    t_sts            sts;
    logic            node_ok;
    logic            key_match;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_BUCKET_BITS) ? 32'(r_bucket_bits) : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bucket_bits <= BUCKET_BITS_RESET;
        end else if (psel && penable && pwrite && paddr[2] == REG_BUCKET_BITS) begin
            r_bucket_bits <= pwdata[BB_W-1:0];
        end
    end

    assign sts.in_valid  = i_req.valid;
    assign sts.out_ready = o_rsp.ready;
    assign sts.node_ok   = node_ok;
    assign sts.key_match = key_match;

    chm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sts       (sts),
        .o_ctl       (ctl),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid)
    );

    chm_datapath #(
        .MAX_BUCKET_BITS (MAX_BUCKET_BITS),
        .NODE_COUNT      (NODE_COUNT),
        .KEY_WIDTH       (KEY_WIDTH),
        .VALUE_WIDTH     (VALUE_WIDTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (ctl),
        .o_node_ok     (node_ok),
        .o_key_match   (key_match),
        .i_cmd         (i_req.cmd),
        .i_key         (i_req.key),
        .i_value       (i_req.value),
        .i_bucket_bits (r_bucket_bits),
        .o_status      (o_rsp.status),
        .o_found_value (o_rsp.found_value),
        .o_entry_count (o_rsp.entry_count)
    );

`ifndef NO_ASSERTIONS
    a_ready_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_req.ready && o_rsp.valid)) else $error("ready while result pending");

    a_no_fast_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !o_rsp.valid) else $error("result too early");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> (int'(o_rsp.entry_count) <= NODE_COUNT))
        else $error("entry count above pool size");

    a_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status != ST_FOUND) |-> (o_rsp.found_value == '0))
        else $error("found value without hit");
`endif

endmodule

// ===== tb/tb.sv =====
// Testbench for the chained hash map engine: drives put, get, remove and unused-code items,
// predicts each response with a behavioral hash table and checks it field by field.
// Depends on chm_pkg, chm_if and the chained_hash_map_engine RTL.
`timescale 1ns / 1ps

module tb;
    import chm_pkg::*;

    localparam int NODES = 256;
    localparam int SLOTS = 128;
    localparam int NIL   = NODES;

    localparam logic [CMD_W-1:0] CMD_NONE         = 2'd3;
    localparam logic [2:0]       ADDR_BUCKET_BITS = 3'd0;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } t_op;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [VAL_W-1:0]    found_value;
        logic [COUNT_W-1:0]  entry_count;
    } t_answer;

    logic i_clk;
    logic i_rst_n;
    logic psel, penable, pwrite;
    logic [2:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    chm_req_if req_ch ();
    chm_rsp_if rsp_ch ();

    chained_hash_map_engine dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow table.
    logic [BB_W-1:0]    tbl_bits;
    int                 tbl_heads [SLOTS];
    logic [KEY_W-1:0]   tbl_keys  [NODES];
    logic [VAL_W-1:0]   tbl_vals  [NODES];
    int                 tbl_links [NODES];
    bit                 tbl_used  [NODES];
    logic [COUNT_W-1:0] tbl_count;

    t_op     pending_ops [$];
    t_answer expected_answers [$];
    logic [KEY_W-1:0] known_keys [$];

    int send_idle_pct;
    int recv_stall_pct;
    int hold_off;
    int mismatches;
    int answers_seen;
    int ops_sent;

    function automatic int bucket_index(logic [KEY_W-1:0] k);
        logic [63:0] h;
        int bits;
        bits = tbl_bits;
        if (bits < MIN_BUCKET_BITS) bits = MIN_BUCKET_BITS;
        if (bits > MAX_BUCKET_BITS_DEF) bits = MAX_BUCKET_BITS_DEF;
        h = k ^ (k >> 32);
        h = h ^ (h >> 16);
        return int'(h & ((64'd1 << bits) - 1));
    endfunction

    function automatic t_answer apply_op(t_op op);
        t_answer a;
        int b, cur, prv, hit, steps, fr;
        a = '0;
        a.status = ST_NOT_FOUND;
        b = bucket_index(op.key);
        cur = tbl_heads[b];
        prv = NIL;
        hit = NIL;
        steps = 0;
        while (steps < NODES && cur < NODES && tbl_used[cur]) begin
            if (tbl_keys[cur] == op.key) begin
                hit = cur;
                break;
            end
            prv = cur;
            cur = tbl_links[cur];
            steps++;
        end
        if (hit == NIL) prv = NIL;
        case (op.cmd)
            CMD_PUT: begin
                if (hit != NIL) begin
                    tbl_vals[hit] = op.value;
                    a.status = ST_UPDATED;
                end else begin
                    fr = NIL;
                    for (int i = 0; i < NODES; i++) begin
                        if (!tbl_used[i]) begin
                            fr = i;
                            break;
                        end
                    end
                    if (fr == NIL) begin
                        a.status = ST_POOL_FULL;
                    end else begin
                        tbl_keys[fr] = op.key;
                        tbl_vals[fr] = op.value;
                        tbl_links[fr] = tbl_heads[b];
                        tbl_used[fr] = 1'b1;
                        tbl_heads[b] = fr;
                        tbl_count = tbl_count + 1'b1;
                        a.status = ST_ADDED;
                    end
                end
            end
            CMD_GET: begin
                if (hit != NIL) begin
                    a.found_value = tbl_vals[hit];
                    a.status = ST_FOUND;
                end
            end
            CMD_REMOVE: begin
                if (hit != NIL) begin
                    if (prv == NIL) tbl_heads[b] = tbl_links[hit];
                    else tbl_links[prv] = tbl_links[hit];
                    tbl_used[hit] = 1'b0;
                    if (tbl_count > 0) tbl_count = tbl_count - 1'b1;
                    a.status = ST_REMOVED;
                end
            end
            default: ;
        endcase
        a.entry_count = tbl_count;
        return a;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Driver.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else if (!req_ch.valid || req_ch.ready) begin
            if (req_ch.valid) begin
                expected_answers.push_back(apply_op({req_ch.cmd, req_ch.key,
                                                     req_ch.value}));
                ops_sent++;
            end
            if (pending_ops.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                t_op op;
                op = pending_ops.pop_front();
                req_ch.valid <= 1'b1;
                req_ch.cmd   <= op.cmd;
                req_ch.key   <= op.key;
                req_ch.value <= op.value;
            end else begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off, counted down in cycles.
    always @(posedge i_clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
        end
    end

    // Monitor.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                t_answer want;
                answers_seen++;
                if (expected_answers.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("tb: response with nothing expected");
                end else begin
                    want = expected_answers.pop_front();
                    if (rsp_ch.status !== want.status
                        || rsp_ch.found_value !== want.found_value
                        || rsp_ch.entry_count !== want.entry_count) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("tb: mismatch exp st=%0d val=%h cnt=%0d got st=%0d val=%h cnt=%0d",
                                     want.status, want.found_value, want.entry_count,
                                     rsp_ch.status, rsp_ch.found_value, rsp_ch.entry_count);
                    end
                end
            end
            if (hold_off > 0) begin
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        tbl_bits = data[BB_W-1:0];
    endtask

    task automatic drain();
        while (pending_ops.size() > 0 || req_ch.valid || expected_answers.size() > 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        int r;
        r = $urandom_range(99);
        if (known_keys.size() > 0 && r < 60)
            return known_keys[$urandom_range(known_keys.size() - 1)];
        if (r < 80) return {$urandom, $urandom};
        return KEY_W'($urandom_range(40));
    endfunction

    task automatic queue_op(logic [CMD_W-1:0] c, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
        pending_ops.push_back({c, k, v});
        if (c == CMD_PUT && known_keys.size() < 400) known_keys.push_back(k);
    endtask

    task automatic queue_random(int n, int put_pct);
        int r;
        logic [CMD_W-1:0] c;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            if (r < put_pct) c = CMD_PUT;
            else if (r < put_pct + (100 - put_pct) / 2) c = CMD_GET;
            else if (r < 98) c = CMD_REMOVE;
            else c = CMD_NONE;
            queue_op(c, pick_key(), {$urandom, $urandom});
        end
    endtask

    initial begin
        int pct [4];
        int stl [4];
        int bits_set [4];
        pct = '{0, 54, 0, 37};
        stl = '{0, 0, 54, 37};
        bits_set = '{4, 7, 5, 6};
        i_rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        req_ch.valid = 1'b0; req_ch.cmd = '0; req_ch.key = '0; req_ch.value = '0;
        rsp_ch.ready = 1'b0;
        send_idle_pct = 0; recv_stall_pct = 0; hold_off = 0;
        mismatches = 0; answers_seen = 0; ops_sent = 0;
        tbl_bits = BUCKET_BITS_RESET;
        tbl_count = '0;
        for (int i = 0; i < SLOTS; i++) tbl_heads[i] = NIL;
        for (int i = 0; i < NODES; i++) begin
            tbl_used[i] = 1'b0;
            tbl_links[i] = NIL;
            tbl_keys[i] = '0;
            tbl_vals[i] = '0;
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extreme keys and values, colliding keys, every command.
        queue_op(CMD_GET, '0, '1);
        queue_op(CMD_PUT, '0, '1);
        queue_op(CMD_PUT, '1, '0);
        queue_op(CMD_PUT, 64'h0000_0001_0000_0001, 64'h1234);
        queue_op(CMD_PUT, 64'h0000_0010_0000_0000, 64'h55);
        queue_op(CMD_PUT, 64'h0000_0000_0000_0010, 64'h66);
        queue_op(CMD_PUT, 64'h0000_0000_0000_0010, 64'h77);
        queue_op(CMD_GET, 64'h0000_0010_0000_0000, '0);
        queue_op(CMD_GET, 64'h0000_0000_0000_0010, '0);
        queue_op(CMD_GET, '1, '1);
        queue_op(CMD_REMOVE, 64'h0000_0010_0000_0000, '0);
        queue_op(CMD_REMOVE, 64'h0000_0010_0000_0000, '0);
        queue_op(CMD_NONE, '1, '1);
        queue_op(CMD_GET, 64'hAAAA_AAAA_AAAA_AAAA, '0);
        queue_op(CMD_REMOVE, '0, '0);
        queue_op(CMD_GET, '0, '0);
        drain();

        // Shrink the bucket count with entries held, then sweep settings.
        apb_write(ADDR_BUCKET_BITS, 32'd4);
        queue_op(CMD_GET, '1, '0);
        queue_op(CMD_PUT, 64'h0000_0001_0000_0001, 64'h9);
        drain();
        for (int ph = 0; ph < 4; ph++) begin
            apb_write(ADDR_BUCKET_BITS, bits_set[ph]);
            send_idle_pct = pct[ph];
            recv_stall_pct = stl[ph];
            queue_random(330, 45);
            drain();
        end
        apb_write(ADDR_BUCKET_BITS, 32'd1);
        queue_random(40, 45);
        drain();

        // Fill the pool past capacity while the receiver holds off.
        send_idle_pct = 0; recv_stall_pct = 0;
        apb_write(ADDR_BUCKET_BITS, 32'd7);
        hold_off = 300;
        for (int i = 0; i < 280; i++) queue_op(CMD_PUT, {$urandom, $urandom}, {$urandom, $urandom});
        queue_random(60, 50);
        drain();
        queue_random(290, 20);
        drain();

        $display("tb: %0d items sent, %0d responses checked across four pacing phases,",
                 ops_sent, answers_seen);
        $display("tb: bucket sizes 16..128 and out of range, and a full node pool");
        if (mismatches == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: %0d mismatches", mismatches);
            $display("tb: FAIL");
        end
        $finish;
    end

    initial begin
        #50ms;
        $display("tb: timeout");
        $display("tb: FAIL");
        $finish;
    end
endmodule

// ===== files.f =====
rtl/chm_pkg.sv
rtl/chm_if.sv
rtl/chm_ctrl.sv
rtl/chm_datapath.sv
rtl/chained_hash_map_engine.sv
tb/tb.sv
